@@ rtl/assert_macros.svh @@
// Assertion helpers for the capability table checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock, off while reset is held.
`define CTAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold at every edge out of reset.
`define CTAP_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (1'b1 |-> (cond))) else $error(msg);

`endif

@@ rtl/ctap_pkg.sv @@
package ctap_pkg;

  // Default sizing
  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam int unsigned CAP_BITS_DEF    = 32;
  localparam int unsigned PID_BITS_DEF    = 16;

  // Fixed field widths of the item payloads
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned PID_IN_W   = 16;
  localparam int unsigned IDX_IN_W   = 5;
  localparam int unsigned MASK_IN_W  = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned S_TDATA_W  = 72;
  localparam int unsigned M_TDATA_W  = 8;

  // Wide staging widths used when cutting ids and masks to size
  localparam int unsigned PID_STAGE_W  = 32;
  localparam int unsigned MASK_STAGE_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_ADD_ROOT = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_CHECK    = 3'd3,
    CMD_SET      = 3'd4,
    CMD_CLEAR    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_PERM   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SRCH,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } state_e;

endpackage

@@ rtl/task_capability_table.sv @@
// Task capability table: up to NUM_ENTRIES entries of task id and capability
// mask, newest first. One command item at a time; every item gives exactly
// one result item. Lookups walk the table from the newest entry through a
// single registered read port and one id comparator, one entry per cycle.
// Set and clear look up the caller first and need its root bit, then look
// up the target; the caller lookup is skipped when a task clears its own
// bit. Remove finds the newest matching entry and then moves each younger
// entry down by one slot. A finished result sits in the output register
// so the next item is taken while it waits. Table contents are not
// cleared by reset; only the entry count is.
module task_capability_table #(
  parameter int unsigned NUM_ENTRIES = ctap_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned CAP_BITS    = ctap_pkg::CAP_BITS_DEF,
  parameter int unsigned PID_BITS    = ctap_pkg::PID_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command, target_pid, caller_pid, cap_index, cap_mask
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ctap_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // status, cap_bit, zero fill
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ctap_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // root_bit_index
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ctap_pkg::IDX_IN_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);

  logic [ctap_pkg::IDX_IN_W-1:0]     root_idx_q;
  logic [ctap_pkg::PID_STAGE_W-1:0]  target_stage;
  logic [ctap_pkg::PID_STAGE_W-1:0]  caller_stage;
  logic [ctap_pkg::MASK_STAGE_W-1:0] mask_stage;
  logic [ctap_pkg::STATUS_W-1:0]     status;
  logic                              cap_bit;

  logic [IDX_W-1:0]    rd_addr;
  logic [PID_BITS-1:0] rd_pid;
  logic [CAP_BITS-1:0] rd_mask;
  logic                we;
  logic [IDX_W-1:0]    wr_addr;
  logic [PID_BITS-1:0] wr_pid;
  logic [CAP_BITS-1:0] wr_mask;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_idx_q <= '0;
    end else if (cfg_valid_i) begin
      root_idx_q <= cfg_data_i;
    end
  end

  // ids and masks cut or zero-extended to the table widths
  assign target_stage = ctap_pkg::PID_STAGE_W'(s_axis_tdata[18:3]);
  assign caller_stage = ctap_pkg::PID_STAGE_W'(s_axis_tdata[34:19]);
  assign mask_stage   = ctap_pkg::MASK_STAGE_W'(s_axis_tdata[71:40]);

  ctap_seq #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .CAP_BITS    (CAP_BITS),
    .PID_BITS    (PID_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tdata[2:0]),
    .target_i    (target_stage[PID_BITS-1:0]),
    .caller_i    (caller_stage[PID_BITS-1:0]),
    .cap_index_i (s_axis_tdata[39:35]),
    .cap_mask_i  (mask_stage[CAP_BITS-1:0]),
    .root_idx_i  (root_idx_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .cap_bit_o   (cap_bit),
    .rd_addr_o   (rd_addr),
    .rd_pid_i    (rd_pid),
    .rd_mask_i   (rd_mask),
    .we_o        (we),
    .wr_addr_o   (wr_addr),
    .wr_pid_o    (wr_pid),
    .wr_mask_o   (wr_mask)
  );

  ctap_store #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .CAP_BITS    (CAP_BITS),
    .PID_BITS    (PID_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_pid_i  (wr_pid),
    .wr_mask_i (wr_mask),
    .rd_addr_i (rd_addr),
    .rd_pid_o  (rd_pid),
    .rd_mask_o (rd_mask)
  );

  assign m_axis_tdata = {5'b0, cap_bit, status};

endmodule

@@ rtl/ctap_store.sv @@
module ctap_store #(
  parameter int unsigned NUM_ENTRIES = ctap_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned CAP_BITS    = ctap_pkg::CAP_BITS_DEF,
  parameter int unsigned PID_BITS    = ctap_pkg::PID_BITS_DEF,
  localparam int unsigned IDX_W      = $clog2(NUM_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  logic [PID_BITS-1:0] wr_pid_i,
  input  logic [CAP_BITS-1:0] wr_mask_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output logic [PID_BITS-1:0] rd_pid_o,
  output logic [CAP_BITS-1:0] rd_mask_o
);

  logic [PID_BITS-1:0] pid_mem  [NUM_ENTRIES];
  logic [CAP_BITS-1:0] mask_mem [NUM_ENTRIES];
  logic [PID_BITS-1:0] rd_pid_q;
  logic [CAP_BITS-1:0] rd_mask_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pid_mem[wr_addr_i]  <= wr_pid_i;
      mask_mem[wr_addr_i] <= wr_mask_i;
    end
    rd_pid_q  <= pid_mem[rd_addr_i];
    rd_mask_q <= mask_mem[rd_addr_i];
  end

  assign rd_pid_o  = rd_pid_q;
  assign rd_mask_o = rd_mask_q;

endmodule

@@ rtl/ctap_seq.sv @@
module ctap_seq #(
  parameter int unsigned NUM_ENTRIES = ctap_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned CAP_BITS    = ctap_pkg::CAP_BITS_DEF,
  parameter int unsigned PID_BITS    = ctap_pkg::PID_BITS_DEF,
  localparam int unsigned IDX_W      = $clog2(NUM_ENTRIES),
  localparam int unsigned CNT_W      = $clog2(NUM_ENTRIES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command side
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ctap_pkg::CMD_W-1:0]      cmd_i,
  input  logic [PID_BITS-1:0]             target_i,
  input  logic [PID_BITS-1:0]             caller_i,
  input  logic [ctap_pkg::IDX_IN_W-1:0]   cap_index_i,
  input  logic [CAP_BITS-1:0]             cap_mask_i,
  input  logic [ctap_pkg::IDX_IN_W-1:0]   root_idx_i,
  // result side
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ctap_pkg::STATUS_W-1:0]   status_o,
  output logic                            cap_bit_o,
  // table store
  output logic [IDX_W-1:0]                rd_addr_o,
  input  logic [PID_BITS-1:0]             rd_pid_i,
  input  logic [CAP_BITS-1:0]             rd_mask_i,
  output logic                            we_o,
  output logic [IDX_W-1:0]                wr_addr_o,
  output logic [PID_BITS-1:0]             wr_pid_o,
  output logic [CAP_BITS-1:0]             wr_mask_o
);

  ctap_pkg::state_e  state_q, state_d;
  ctap_pkg::cmd_e    cmd_q, cmd_d;
  ctap_pkg::status_e status_q, status_d;
  logic                capb_q, capb_d;
  logic [PID_BITS-1:0] target_q, target_d;
  logic [PID_BITS-1:0] caller_q, caller_d;
  logic [CAP_BITS-1:0] cap_sel_q, cap_sel_d;
  logic [CAP_BITS-1:0] mask_q, mask_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                cmp_valid_q, cmp_valid_d;
  logic                phase_q, phase_d;   // 0: caller lookup, 1: target lookup
  logic                out_valid_q, out_valid_d;
  ctap_pkg::status_e out_status_q, out_status_d;
  logic                out_capb_q, out_capb_d;

  logic [CAP_BITS-1:0] cap_dec;
  logic [CAP_BITS-1:0] root_sel;
  logic [PID_BITS-1:0] key;
  logic                hit;
  logic                miss;
  logic                clr_self;
  logic [CNT_W-1:0]    next_k;

  // One-hot bit selects; an index beyond the mask width selects nothing
  always_comb begin
    for (int i = 0; i < int'(CAP_BITS); i++) begin
      cap_dec[i]  = (int'(cap_index_i) == i);
      root_sel[i] = (int'(root_idx_i) == i);
    end
  end

  // Shared id comparator
  assign key      = phase_q ? target_q : caller_q;
  assign hit      = cmp_valid_q && (rd_pid_i == key);
  assign miss     = cmp_valid_q && !hit && (cmp_idx_q == '0);
  assign clr_self = (cmd_q == ctap_pkg::CMD_CLEAR) && (caller_q == target_q);
  assign next_k   = CNT_W'(ptr_q) + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    status_d     = status_q;
    capb_d       = capb_q;
    target_d     = target_q;
    caller_d     = caller_q;
    cap_sel_d    = cap_sel_q;
    mask_d       = mask_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_valid_d  = cmp_valid_q;
    phase_d      = phase_q;
    out_status_d = out_status_q;
    out_capb_d   = out_capb_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    rd_addr_o    = ptr_q;
    we_o         = 1'b0;
    wr_addr_o    = IDX_W'(count_q);
    wr_pid_o     = target_q;
    wr_mask_o    = mask_q;

    unique case (state_q)
      ctap_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d     = ctap_pkg::cmd_e'(cmd_i);
          target_d  = target_i;
          caller_d  = caller_i;
          cap_sel_d = cap_dec;
          mask_d    = cap_mask_i;
          status_d  = ctap_pkg::ST_OK;
          capb_d    = 1'b0;
          state_d   = ctap_pkg::S_DISP;
        end
      end

      ctap_pkg::S_DISP: begin
        state_d     = ctap_pkg::S_RESP;
        cmp_valid_d = 1'b0;
        ptr_d       = IDX_W'(count_q - CNT_W'(1));
        unique case (cmd_q)
          ctap_pkg::CMD_ADD, ctap_pkg::CMD_ADD_ROOT: begin
            if (count_q == CNT_W'(NUM_ENTRIES)) begin
              status_d = ctap_pkg::ST_FULL;
            end else begin
              we_o      = 1'b1;
              wr_mask_o = (cmd_q == ctap_pkg::CMD_ADD_ROOT) ? '1 : mask_q;
              count_d   = count_q + CNT_W'(1);
            end
          end
          ctap_pkg::CMD_REMOVE, ctap_pkg::CMD_CHECK: begin
            phase_d = 1'b1;
            if (count_q == '0) begin
              status_d = ctap_pkg::ST_NOT_FOUND;
            end else begin
              state_d = ctap_pkg::S_SRCH;
            end
          end
          ctap_pkg::CMD_SET, ctap_pkg::CMD_CLEAR: begin
            // clearing one's own bit needs no root check
            phase_d = clr_self;
            if (count_q == '0) begin
              status_d = clr_self ? ctap_pkg::ST_NOT_FOUND : ctap_pkg::ST_NO_PERM;
            end else begin
              state_d = ctap_pkg::S_SRCH;
            end
          end
          default: ;
        endcase
      end

      // newest to oldest, one compare per cycle behind the registered read
      ctap_pkg::S_SRCH: begin
        if (hit) begin
          if (!phase_q) begin
            if ((rd_mask_i & root_sel) != '0) begin
              phase_d     = 1'b1;
              cmp_valid_d = 1'b0;
              ptr_d       = IDX_W'(count_q - CNT_W'(1));
            end else begin
              status_d = ctap_pkg::ST_NO_PERM;
              state_d  = ctap_pkg::S_RESP;
            end
          end else begin
            state_d = ctap_pkg::S_RESP;
            unique case (cmd_q)
              ctap_pkg::CMD_CHECK: begin
                capb_d = (rd_mask_i & cap_sel_q) != '0;
              end
              ctap_pkg::CMD_SET: begin
                we_o      = 1'b1;
                wr_addr_o = cmp_idx_q;
                wr_pid_o  = rd_pid_i;
                wr_mask_o = rd_mask_i | cap_sel_q;
              end
              ctap_pkg::CMD_CLEAR: begin
                we_o      = 1'b1;
                wr_addr_o = cmp_idx_q;
                wr_pid_o  = rd_pid_i;
                wr_mask_o = rd_mask_i & ~cap_sel_q;
              end
              ctap_pkg::CMD_REMOVE: begin
                ptr_d   = cmp_idx_q;
                state_d = ctap_pkg::S_SH_RD;
              end
              default: ;
            endcase
          end
        end else if (miss) begin
          status_d = phase_q ? ctap_pkg::ST_NOT_FOUND : ctap_pkg::ST_NO_PERM;
          state_d  = ctap_pkg::S_RESP;
        end else begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = ptr_q;
          ptr_d       = ptr_q - IDX_W'(1);
        end
      end

      // close the gap left by a removed entry
      ctap_pkg::S_SH_RD: begin
        if (next_k >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = ctap_pkg::S_RESP;
        end else begin
          rd_addr_o = ptr_q + IDX_W'(1);
          state_d   = ctap_pkg::S_SH_WR;
        end
      end

      ctap_pkg::S_SH_WR: begin
        we_o      = 1'b1;
        wr_addr_o = ptr_q;
        wr_pid_o  = rd_pid_i;
        wr_mask_o = rd_mask_i;
        ptr_d     = ptr_q + IDX_W'(1);
        state_d   = ctap_pkg::S_SH_RD;
      end

      ctap_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_capb_d   = capb_q;
          state_d      = ctap_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctap_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cmp_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      cmp_valid_q <= cmp_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    status_q     <= status_d;
    capb_q       <= capb_d;
    target_q     <= target_d;
    caller_q     <= caller_d;
    cap_sel_q    <= cap_sel_d;
    mask_q       <= mask_d;
    ptr_q        <= ptr_d;
    cmp_idx_q    <= cmp_idx_d;
    out_status_q <= out_status_d;
    out_capb_q   <= out_capb_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign cap_bit_o   = out_capb_q;

endmodule

@@ rtl/ctap_checker.sv @@
`include "assert_macros.svh"

module ctap_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ctap_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic in_take;
  logic out_stall;
  logic capb_bad;

  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign capb_bad  = m_axis_tvalid && m_axis_tdata[2] &&
                     (m_axis_tdata[1:0] != ctap_pkg::ST_OK);

  // a held result keeps its value
  `CTAP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result not held")

  `CTAP_ALWAYS(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[7:3] == '0), "fill bits set")

  // a set cap bit only comes with an ok status
  `CTAP_ALWAYS(a_capb_ok, !capb_bad, "cap bit with error status")

  // every item passes through the dispatch and response states before the next is taken
  `CTAP_ASSERT(a_busy_after_take, in_take |=> !s_axis_tready, "item taken back to back")

endmodule

bind task_capability_table ctap_checker u_ctap_checker (.*);

@@ tb/sv/task_capability_table_tb.sv @@
`timescale 1ns / 1ps

module task_capability_table_tb;
  import ctap_pkg::*;

  localparam int unsigned SLOTS          = NUM_ENTRIES_DEF;
  localparam int unsigned LIMIT_CYCLES   = 1000000;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES  = 50;
  localparam int unsigned MAX_REPORTS    = 10;

  // codes the block has no command for
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  // packed struct: first member is the top of the vector, so command ends up in bit 0
  typedef struct packed {
    logic [MASK_IN_W-1:0] cap_mask;
    logic [IDX_IN_W-1:0]  cap_index;
    logic [PID_IN_W-1:0]  caller_pid;
    logic [PID_IN_W-1:0]  target_pid;
    logic [CMD_W-1:0]     command;
  } cap_cmd_t;

  typedef struct packed {
    logic [4:0]          fill;
    logic                cap_bit;
    logic [STATUS_W-1:0] status;
  } cap_resp_t;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  class cap_table_scoreboard;
    logic [PID_IN_W-1:0]  pid_tab[SLOTS];
    logic [MASK_IN_W-1:0] mask_tab[SLOTS];
    int unsigned          used;
    logic [IDX_IN_W-1:0]  root_bit;
    cap_resp_t            expected_q[$];
    int unsigned          mismatches;
    int unsigned          checked;
    int unsigned          items;
    int unsigned          status_seen[4];

    function new();
      used       = 0;
      root_bit   = '0;
      mismatches = 0;
      checked    = 0;
      items      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int newest_slot(logic [PID_IN_W-1:0] pid);
      int i;
      for (i = int'(used) - 1; i >= 0; i--) begin
        if (pid_tab[i] == pid) return i;
      end
      return -1;
    endfunction

    // update the table copy for one accepted item and queue its result
    function void note_command(cap_cmd_t c);
      cap_resp_t r;
      int        t;
      int        k;
      int        caller_slot;
      bit        allowed;
      r        = '0;
      r.status = ST_OK;
      case (c.command)
        CMD_ADD, CMD_ADD_ROOT: begin
          if (used >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            pid_tab[used]  = c.target_pid;
            mask_tab[used] = (c.command == CMD_ADD) ? c.cap_mask : '1;
            used++;
          end
        end
        CMD_REMOVE: begin
          t = newest_slot(c.target_pid);
          if (t < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (k = t; k + 1 < int'(used); k++) begin
              pid_tab[k]  = pid_tab[k+1];
              mask_tab[k] = mask_tab[k+1];
            end
            used--;
          end
        end
        CMD_CHECK: begin
          t = newest_slot(c.target_pid);
          if (t < 0) r.status = ST_NOT_FOUND;
          else       r.cap_bit = mask_tab[t][c.cap_index];
        end
        CMD_SET, CMD_CLEAR: begin
          // caller permission first, target lookup only once allowed
          caller_slot = newest_slot(c.caller_pid);
          allowed = (caller_slot >= 0) && mask_tab[caller_slot][root_bit];
          if (c.command == CMD_CLEAR && c.caller_pid == c.target_pid) allowed = 1'b1;
          if (!allowed) begin
            r.status = ST_NO_PERM;
          end else begin
            t = newest_slot(c.target_pid);
            if (t < 0) r.status = ST_NOT_FOUND;
            else       mask_tab[t][c.cap_index] = (c.command == CMD_SET);
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
      items++;
    endfunction

    function void check_result(cap_resp_t got);
      cap_resp_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item %h with nothing outstanding", got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (!$isunknown(got.status)) status_seen[got.status]++;
      if (got.status !== want.status || got.cap_bit !== want.cap_bit ||
          got.fill !== want.fill) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: status exp %0d got %0d, cap_bit exp %0d got %0d, fill exp %h got %h",
                   checked, want.status, got.status, want.cap_bit, got.cap_bit,
                   want.fill, got.fill);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [IDX_IN_W-1:0]    cfg_data_i;

  cap_table_scoreboard    sb = new();
  idle_mode_e             idle_mode = IDLE_NONE;
  int unsigned            cycle_count = 0;
  int unsigned            rx_hold_left = 0;
  bit                     rx_hold_req = 1'b0;
  logic [PID_IN_W-1:0]    pid_pool[6];

  task_capability_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.outstanding());
      $display("task_capability_table verification failed");
      $finish;
    end
  end

  function automatic bit src_idles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    return (idle_mode == IDLE_SRC && roll < 87) || (idle_mode == IDLE_BOTH && roll < 11);
  endfunction

  function automatic bit snk_stalls();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    return (idle_mode == IDLE_SNK && roll < 87) || (idle_mode == IDLE_BOTH && roll < 11);
  endfunction

  // result side: check on handshake, then choose ready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(cap_resp_t'(m_axis_tdata));
      if (rx_hold_req && rx_hold_left == 0) rx_hold_left = RX_HOLD_CYCLES;
      if (rx_hold_left != 0) begin
        rx_hold_left = rx_hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !snk_stalls();
      end
    end
  end

  task automatic offer_command(input cap_cmd_t c);
    if (src_idles()) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (src_idles());
    end
    s_axis_tdata  <= c;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(c);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_root_bit(input logic [IDX_IN_W-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.root_bit = v;
  endtask

  function automatic cap_cmd_t make_cmd(logic [CMD_W-1:0] op, logic [PID_IN_W-1:0] tgt,
                                        logic [PID_IN_W-1:0] clr, logic [IDX_IN_W-1:0] idx,
                                        logic [MASK_IN_W-1:0] mask);
    cap_cmd_t c;
    c.command    = op;
    c.target_pid = tgt;
    c.caller_pid = clr;
    c.cap_index  = idx;
    c.cap_mask   = mask;
    return c;
  endfunction

  // mostly ids already in the table or from a small pool, so lookups hit
  function automatic logic [PID_IN_W-1:0] pick_pid();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45 && sb.used != 0) return sb.pid_tab[$urandom_range(0, sb.used - 1)];
    if (roll < 85) return pid_pool[$urandom_range(0, 5)];
    return PID_IN_W'($urandom);
  endfunction

  function automatic cap_cmd_t random_command();
    cap_cmd_t    c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if      (roll < 22) c.command = CMD_ADD;
    else if (roll < 28) c.command = CMD_ADD_ROOT;
    else if (roll < 44) c.command = CMD_REMOVE;
    else if (roll < 62) c.command = CMD_CHECK;
    else if (roll < 79) c.command = CMD_SET;
    else if (roll < 96) c.command = CMD_CLEAR;
    else if (roll < 98) c.command = CMD_SPARE_A;
    else                c.command = CMD_SPARE_B;
    c.target_pid = pick_pid();
    c.caller_pid = ($urandom_range(0, 99) < 20) ? c.target_pid : pick_pid();
    c.cap_index  = ($urandom_range(0, 99) < 20) ? sb.root_bit : IDX_IN_W'($urandom);
    roll = $urandom_range(0, 99);
    if      (roll < 10) c.cap_mask = '0;
    else if (roll < 20) c.cap_mask = '1;
    else                c.cap_mask = $urandom;
    return c;
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned k;
    int unsigned burst;
    int unsigned roll;
    cap_cmd_t    c;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // fill past capacity
        burst = SLOTS + 2;
        for (k = 0; k < burst; k++) begin
          c = random_command();
          c.command = ($urandom_range(0, 3) == 0) ? CMD_ADD_ROOT : CMD_ADD;
          offer_command(c);
        end
        sent += burst;
      end else if (roll < 5) begin
        // empty the table, one extra remove hits an absent id
        burst = sb.used + 1;
        for (k = 0; k < burst; k++) begin
          c = random_command();
          c.command = CMD_REMOVE;
          if (sb.used != 0) c.target_pid = sb.pid_tab[$urandom_range(0, sb.used - 1)];
          offer_command(c);
        end
        sent += burst;
      end else begin
        offer_command(random_command());
        sent++;
      end
    end
  endtask

  task automatic run_directed();
    offer_command(make_cmd(CMD_CHECK, '0, '0, '0, '0));
    offer_command(make_cmd(CMD_REMOVE, '1, '0, '0, '0));
    offer_command(make_cmd(CMD_SET, 16'h1234, 16'h0bad, 5'd3, '0));
    offer_command(make_cmd(CMD_CLEAR, 16'h0bad, 16'h0bad, 5'd3, '0));
    offer_command(make_cmd(CMD_ADD_ROOT, '1, '0, '0, '0));
    offer_command(make_cmd(CMD_ADD, '0, '0, '0, '1));
    offer_command(make_cmd(CMD_ADD, 16'h1234, '0, '0, '0));
    offer_command(make_cmd(CMD_ADD, 16'h1234, '0, '0, 32'h8000_0001));
    offer_command(make_cmd(CMD_CHECK, 16'h1234, '0, 5'd31, '0));
    offer_command(make_cmd(CMD_CHECK, 16'h1234, '0, 5'd0, '0));
    offer_command(make_cmd(CMD_SET, 16'h1234, '1, 5'd5, '0));
    // a task may drop its own bit without the root bit
    offer_command(make_cmd(CMD_CLEAR, 16'h1234, 16'h1234, 5'd0, '0));
    offer_command(make_cmd(CMD_CLEAR, 16'h1234, '0, 5'd31, '0));
    offer_command(make_cmd(CMD_SET, '0, 16'h1234, 5'd7, '0));
    offer_command(make_cmd(CMD_SET, 16'h5555, '1, 5'd7, '0));
    offer_command(make_cmd(CMD_CLEAR, '0, 16'h1234, 5'd7, '0));
    offer_command(make_cmd(CMD_REMOVE, 16'h1234, '0, '0, '0));
    offer_command(make_cmd(CMD_CHECK, 16'h1234, '0, 5'd31, '0));
    offer_command(make_cmd(CMD_CHECK, '1, '0, 5'd31, '0));
    offer_command(make_cmd(CMD_SPARE_A, '1, '1, '1, '1));
    offer_command(make_cmd(CMD_SPARE_B, '0, '0, '0, '0));
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    pid_pool[2] = 16'h1234;
    foreach (pid_pool[i]) if (i > 2) pid_pool[i] = PID_IN_W'($urandom);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // root bit left at its reset value for the directed items
    run_directed();
    drain_results();

    write_root_bit(5'd31);
    idle_mode = IDLE_NONE;
    run_random(110);
    drain_results();

    write_root_bit(5'd0);
    idle_mode = IDLE_SRC;
    run_random(100);
    drain_results();

    write_root_bit(IDX_IN_W'($urandom_range(1, 30)));
    idle_mode = IDLE_SNK;
    run_random(100);
    drain_results();

    write_root_bit(IDX_IN_W'($urandom_range(1, 30)));
    idle_mode = IDLE_BOTH;
    run_random(100);
    drain_results();

    // output held off while items keep coming, input must back up
    write_root_bit(5'd31);
    idle_mode   = IDLE_NONE;
    rx_hold_req = 1'b1;
    wait (rx_hold_left != 0);
    rx_hold_req = 1'b0;
    run_random(60);
    drain_results();

    write_root_bit(5'd0);
    idle_mode = IDLE_BOTH;
    run_random(80);
    drain_results();

    $display("%0d command items, %0d results checked; ok %0d, not found %0d, no perm %0d, full %0d",
             sb.items, sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_NO_PERM], sb.status_seen[ST_FULL]);
    $display("root bit at 0, 31 and mid-range; gaps and stalls on both sides, %0d-cycle output hold",
             RX_HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("task_capability_table verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.outstanding());
      $display("task_capability_table verification failed");
    end
    $finish;
  end

endmodule

@@ task_capability_table.f @@
+incdir+rtl
rtl/ctap_pkg.sv
rtl/ctap_store.sv
rtl/ctap_seq.sv
rtl/task_capability_table.sv
rtl/ctap_checker.sv
tb/sv/task_capability_table_tb.sv
